### sv/ebs_pkg.sv
// Shared types and codes for the embedding-bag sum pooling block.
`timescale 1ns / 1ps

package ebs_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_ACCUM = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_MUL,
        ST_CHECK,
        ST_ACC_RUN,
        ST_ACC_DRAIN,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic col_clear;
        logic col_inc;
        logic tab_write;
        logic base_load;
        logic set_err;
        logic acc_read;
        logic emit_read;
        logic out_load;
        logic bag_clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic row_oob;
        logic col_last;
        logic out_busy;
    } stat_t;

endpackage

### sv/ebs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ebs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/ebs_ctrl.sv
// Controller state machine that sequences writes, row accumulation and row emission.
`timescale 1ns / 1ps

module ebs_ctrl
    import ebs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic [1:0]  s_op,
    output logic        s_tready,
    output logic        cfg_ready,
    input  stat_t       stat,
    output cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cfg_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    cmd.col_clear = 1'b1;
                    unique case (op_t'(s_op))
                        OP_WRITE: state_next = ST_WRITE;
                        OP_ACCUM: state_next = ST_MUL;
                        OP_CLOSE: state_next = ST_EMIT_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: begin
                cmd.tab_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_MUL: begin
                cmd.base_load = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.row_oob) begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_ACC_RUN;
                end
            end
            ST_ACC_RUN: begin
                cmd.acc_read = 1'b1;
                if (stat.col_last) begin
                    state_next = ST_ACC_DRAIN;
                end else begin
                    cmd.col_inc = 1'b1;
                end
            end
            ST_ACC_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_EMIT_READ: begin
                if (!stat.out_busy) begin
                    cmd.emit_read = 1'b1;
                    state_next    = ST_EMIT_LOAD;
                end
            end
            ST_EMIT_LOAD: begin
                cmd.out_load = 1'b1;
                if (stat.col_last) begin
                    cmd.bag_clear = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.col_inc = 1'b1;
                    state_next  = ST_EMIT_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/ebs_datapath.sv
// Datapath: table and accumulator memories, column counter, adder and output register.
`timescale 1ns / 1ps

module ebs_datapath
    import ebs_pkg::*;
#(
    parameter int TABLE_WORDS = 65536,
    parameter int MAX_COLUMNS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser,
    input  cmd_t        cmd,
    output stat_t       stat
);

    localparam int COL_MAX = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;
    localparam int ACC_AW  = (COL_MAX > 1) ? $clog2(COL_MAX) : 1;
    localparam int TAB_AW  = $clog2(TABLE_WORDS);
    localparam logic [6:0]  WIDTH_MAX = 7'(COL_MAX);
    localparam logic [6:0]  WIDTH_RST = (COL_MAX < 16) ? 7'(COL_MAX) : 7'd16;
    localparam logic [25:0] TAB_LIMIT = 26'(TABLE_WORDS);

    logic [15:0]        addr_reg,     addr_next;
    logic [31:0]        value_reg,    value_next;
    logic [15:0]        row_reg,      row_next;
    logic [6:0]         width_reg,    width_next;
    logic [22:0]        base_reg,     base_next;
    logic [6:0]         col_reg,      col_next;
    logic               err_reg,      err_next;
    logic [COL_MAX-1:0] acc_vld_reg,  acc_vld_next;
    logic               pend_reg,     pend_next;
    logic [ACC_AW-1:0]  pend_col_reg, pend_col_next;
    logic               rd_vld_reg,   rd_vld_next;
    logic               out_vld_reg,  out_vld_next;
    logic [5:0]         out_col_reg,  out_col_next;
    logic [31:0]        out_sum_reg,  out_sum_next;
    logic               out_last_reg, out_last_next;
    logic               out_bad_reg,  out_bad_next;

    logic [ACC_AW-1:0]  col_idx;
    logic [23:0]        wr_addr_full;
    logic [23:0]        rd_addr_full;
    logic               addr_ok;
    logic               acc_re;
    logic [31:0]        tab_rdata;
    logic [31:0]        acc_rdata;
    logic [31:0]        acc_old;
    logic [31:0]        acc_sum;

    assign col_idx      = col_reg[ACC_AW-1:0];
    assign wr_addr_full = 24'(addr_reg);
    assign rd_addr_full = 24'(base_reg) + 24'(col_reg);
    assign addr_ok      = 26'(addr_reg) < TAB_LIMIT;
    assign acc_re       = cmd.acc_read | cmd.emit_read;
    assign acc_old      = rd_vld_reg ? acc_rdata : 32'd0;
    assign acc_sum      = acc_old + tab_rdata;

    assign stat.row_oob  = (26'(base_reg) + 26'(width_reg)) > TAB_LIMIT;
    assign stat.col_last = (col_reg + 7'd1) == width_reg;
    assign stat.out_busy = out_vld_reg & ~m_tready;

    ebs_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.tab_write & addr_ok),
        .wr_addr (wr_addr_full[TAB_AW-1:0]),
        .wr_data (value_reg),
        .rd_en   (cmd.acc_read),
        .rd_addr (rd_addr_full[TAB_AW-1:0]),
        .rd_data (tab_rdata)
    );

    ebs_ram #(
        .WIDTH (32),
        .DEPTH (COL_MAX)
    ) u_accum (
        .aclk    (aclk),
        .wr_en   (pend_reg),
        .wr_addr (pend_col_reg),
        .wr_data (acc_sum),
        .rd_en   (acc_re),
        .rd_addr (col_idx),
        .rd_data (acc_rdata)
    );

    always_comb begin
        addr_next     = addr_reg;
        value_next    = value_reg;
        row_next      = row_reg;
        width_next    = width_reg;
        base_next     = base_reg;
        col_next      = col_reg;
        err_next      = err_reg;
        acc_vld_next  = acc_vld_reg;
        pend_next     = cmd.acc_read;
        pend_col_next = col_idx;
        rd_vld_next   = rd_vld_reg;
        out_vld_next  = out_vld_reg;
        out_col_next  = out_col_reg;
        out_sum_next  = out_sum_reg;
        out_last_next = out_last_reg;
        out_bad_next  = out_bad_reg;

        if (cmd.load_item) begin
            addr_next  = s_tdata[15:0];
            value_next = s_tdata[47:16];
            row_next   = s_tdata[63:48];
        end

        // Width is clamped once on the way in so the datapath never sees zero.
        if (cfg_valid && cfg_ready) begin
            if (cfg_data == 7'd0) begin
                width_next = 7'd1;
            end else if (cfg_data > WIDTH_MAX) begin
                width_next = WIDTH_MAX;
            end else begin
                width_next = cfg_data;
            end
        end

        if (cmd.base_load) begin
            base_next = 23'(row_reg) * 23'(width_reg);
        end

        if (cmd.col_clear) begin
            col_next = 7'd0;
        end else if (cmd.col_inc) begin
            col_next = col_reg + 7'd1;
        end

        if (acc_re) begin
            rd_vld_next = acc_vld_reg[col_idx];
        end

        if (cmd.bag_clear) begin
            acc_vld_next = '0;
            err_next     = 1'b0;
        end else begin
            if (pend_reg) begin
                acc_vld_next[pend_col_reg] = 1'b1;
            end
            if (cmd.set_err) begin
                err_next = 1'b1;
            end
        end

        if (cmd.out_load) begin
            out_vld_next  = 1'b1;
            out_col_next  = col_reg[5:0];
            out_sum_next  = acc_old;
            out_last_next = stat.col_last;
            out_bad_next  = err_reg;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RST;
            col_reg     <= 7'd0;
            err_reg     <= 1'b0;
            acc_vld_reg <= '0;
            pend_reg    <= 1'b0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            col_reg     <= col_next;
            err_reg     <= err_next;
            acc_vld_reg <= acc_vld_next;
            pend_reg    <= pend_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        value_reg    <= value_next;
        row_reg      <= row_next;
        base_reg     <= base_next;
        pend_col_reg <= pend_col_next;
        out_col_reg  <= out_col_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_sum_reg, out_col_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

endmodule

### sv/embedding_bag_sum.sv
// Top level of the embedding-bag sum pooling block.
//
// Input transactions arrive on the s_ channel with the item kind on s_tuser:
// a write stores one signed word into the embedding table, an accumulate adds
// table row row_index (row_width words starting at row_index * row_width) into
// the row accumulator, and a close emits the accumulated row on the m_ channel,
// one column per transaction, with m_tlast on the final column.
// A write is a single table store. An accumulate runs the row address multiply
// and the bounds check, then one column per cycle through the table and
// accumulator memories, and ends with the last write-back. A close does a
// read-then-load of each column from the accumulator memory, pausing while
// the receiver is not ready. Items are processed one at a time.
// A row that would reach past the table end is skipped and m_tuser is raised on
// every column of the next emitted row. The cfg channel sets row_width; it is
// accepted between items. Reset clears the accumulator through per-column valid
// bits at once, sets row_width to 16 and needs no clearing pass; table words
// are undefined until written. When the receiver stalls, the current column
// waits in the output register and the emission pauses until it is taken.
`timescale 1ns / 1ps

module embedding_bag_sum
    import ebs_pkg::*;
#(
    parameter int TABLE_WORDS = 65536,
    parameter int MAX_COLUMNS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // table_address[15:0], table_value[47:16], row_index[63:48]
    input  logic [1:0]  s_tuser,  // op[1:0]
    // Row width register.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    // Pooled results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // column[5:0], sum[37:6], zero[39:38]
    output logic        m_tlast,
    output logic        m_tuser   // bad_index[0]
);

    cmd_t  cmd;
    stat_t stat;

    // The controller only sequences; all storage and arithmetic live in the datapath.
    ebs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_op      (s_tuser),
        .s_tready  (s_tready),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ebs_datapath #(
        .TABLE_WORDS (TABLE_WORDS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### tb/tb_embedding_bag_sum.sv
// Self-checking testbench for the embedding-bag sum pooling block, random and directed bags.
`timescale 1ns / 1ps

module tb_embedding_bag_sum;
    import ebs_pkg::*;

    localparam int TABLE_WORDS = 65536;
    localparam int MAX_COLUMNS = 64;
    // The item kind that the block must drop without producing anything.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Long enough to settle any item that is still in flight when no row is pending.
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 52;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [31:0] value;
        logic [15:0] row;
    } bag_item_t;

    typedef struct {
        logic [5:0]  column;
        logic [31:0] sum;
        logic        last;
        logic        bad;
    } pooled_col_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // table_address[15:0], table_value[47:16], row_index[63:48]
    logic [1:0]  s_tuser = '0;   // op[1:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // column[5:0], sum[37:6], zero[39:38]
    logic        m_tlast;
    logic        m_tuser;        // bad_index[0]

    // Items waiting for the driver.
    bag_item_t   pending_items[$];
    bag_item_t   next_item;
    int unsigned items_pushed = 0;
    int unsigned items_accepted = 0;

    // Predicted block state, advanced on every accepted transaction.
    logic [31:0] emb_words [0:TABLE_WORDS-1];
    logic [31:0] acc_cols [0:MAX_COLUMNS-1];
    logic        bag_err = 1'b0;
    logic [6:0]  model_width = 7'd16;
    pooled_col_t pooled_q[$];

    logic        s_taken = 1'b0;
    logic        rx_block = 1'b0;
    event        hold_start;
    int unsigned send_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    embedding_bag_sum dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The effective row width: zero acts as one column, anything past the
    // accumulator size acts as the full accumulator.
    function automatic int unsigned clamp_width(input logic [6:0] w);
        if (w == 7'd0) begin
            return 1;
        end
        if (w > MAX_COLUMNS) begin
            return MAX_COLUMNS;
        end
        return {25'd0, w};
    endfunction

    // Table words lean on the extremes so that column sums wrap often.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: begin
                return 32'h7fff_ffff;
            end
            1: begin
                return 32'h8000_0000;
            end
            2: begin
                return 32'hffff_ffff;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Only the low 16 bits of the address and row arguments reach the block.
    task automatic push_item(input logic [1:0] op, input int unsigned addr,
                             input logic [31:0] value, input int unsigned row);
        bag_item_t it;
        it.op = op;
        it.addr = addr[15:0];
        it.value = value;
        it.row = row[15:0];
        pending_items.push_back(it);
        items_pushed++;
    endtask

    // Advances the predicted state by one accepted item and queues the
    // pooled columns that a close produces.
    task automatic pool_step(input logic [1:0] op, input logic [15:0] addr,
                             input logic [31:0] value, input logic [15:0] row);
        int unsigned w;
        int unsigned base;
        int unsigned c;
        pooled_col_t col;
        w = clamp_width(model_width);
        case (op)
            OP_WRITE: begin
                emb_words[addr] = value;
            end
            OP_ACCUM: begin
                base = row * w;
                if (base + w > TABLE_WORDS) begin
                    bag_err = 1'b1;
                end else begin
                    for (c = 0; c < w; c++) begin
                        acc_cols[c] = acc_cols[c] + emb_words[base + c];
                    end
                end
            end
            OP_CLOSE: begin
                for (c = 0; c < w; c++) begin
                    col.column = c[5:0];
                    col.sum = acc_cols[c];
                    col.last = (c + 1 == w);
                    col.bad = bag_err;
                    pooled_q.push_back(col);
                end
                for (c = 0; c < MAX_COLUMNS; c++) begin
                    acc_cols[c] = '0;
                end
                bag_err = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_column(input logic [39:0] data, input logic last, input logic bad);
        pooled_col_t want;
        if (pooled_q.size() == 0) begin
            flag_mismatch("column with no close pending", 32'(data[5:0]), 32'd0);
        end else begin
            want = pooled_q.pop_front();
            if (data[5:0] !== want.column) begin
                flag_mismatch("column", 32'(data[5:0]), 32'(want.column));
            end
            if (data[37:6] !== want.sum) begin
                flag_mismatch("sum", data[37:6], want.sum);
            end
            if (last !== want.last) begin
                flag_mismatch("last", 32'(last), 32'(want.last));
            end
            if (bad !== want.bad) begin
                flag_mismatch("bad_index", 32'(bad), 32'(want.bad));
            end
        end
    endtask

    // The row width register may only change while the block is idle.
    task automatic load_row_width(input logic [6:0] w);
        @(negedge aclk);
        cfg_data <= w;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every item has been taken and every pooled column checked,
    // then lets any write or accumulate still inside the block finish.
    task automatic wait_for_quiet();
        while (items_accepted != items_pushed || pooled_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Driver: a new item goes out at the falling edge once the previous one
    // was taken. s_taken records whether the last rising edge completed a
    // transaction on the input channel.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                s_tdata <= {next_item.row, next_item.value, next_item.addr};
                s_tuser <= next_item.op;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold: once started, ready stays low while the sender keeps going.
    always begin
        @(hold_start);
        rx_block = 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        rx_block = 1'b0;
    end

    // Receiver: ready is held low during a long hold and dropped at random
    // according to the stall rate of the current phase.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !rx_block && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor: all handshakes are sampled at the rising edge. Register writes
    // and input items update the predicted state in the order the block sees
    // them; each output transaction is checked against the oldest column.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                model_width = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                pool_step(s_tuser, s_tdata[15:0], s_tdata[47:16], s_tdata[63:48]);
                items_accepted++;
            end
            if (m_tvalid && m_tready) begin
                check_column(m_tdata, m_tlast, m_tuser);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned i;
        int unsigned c;
        int unsigned k;
        int unsigned n;
        int unsigned phase;
        int unsigned eff;
        int unsigned nrows;
        int unsigned made;
        int unsigned pick;
        logic [6:0]  width_val;
        logic [15:0] known_rows[$];

        for (i = 0; i < MAX_COLUMNS; i++) begin
            acc_cols[i] = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed bag at the reset width of 16: row 0 holds both extremes and
        // all ones, and is added twice so that those columns wrap. The row at
        // index 65535 lies past the table end, so the bag is flagged, and the
        // close that follows shows an empty bag with the flag cleared.
        push_item(OP_WRITE, 0, 32'h7fff_ffff, $urandom);
        push_item(OP_WRITE, 1, 32'h8000_0000, $urandom);
        push_item(OP_WRITE, 2, 32'hffff_ffff, $urandom);
        push_item(OP_WRITE, 3, 32'h0000_0001, $urandom);
        for (i = 4; i < 16; i++) begin
            push_item(OP_WRITE, i, $urandom, $urandom);
        end
        push_item(OP_WRITE, 65535, 32'h8000_0000, $urandom);
        push_item(OP_ACCUM, $urandom, $urandom, 0);
        push_item(OP_ACCUM, $urandom, $urandom, 0);
        push_item(OP_ACCUM, $urandom, $urandom, 65535);
        push_item(OP_UNUSED, $urandom, $urandom, $urandom);
        push_item(OP_CLOSE, $urandom, $urandom, $urandom);
        push_item(OP_CLOSE, $urandom, $urandom, $urandom);
        wait_for_quiet();

        for (phase = 0; phase < 8; phase++) begin
            // Each phase has its own row width, including the clamped values
            // zero and 127, and its own mix of sender gaps and receiver stalls.
            case (phase)
                0: begin
                    width_val = 7'd1;   send_idle_pct = 75; rx_stall_pct = 0;
                end
                1: begin
                    width_val = 7'd64;  send_idle_pct = 0;  rx_stall_pct = 75;
                end
                2: begin
                    width_val = 7'd0;   send_idle_pct = 25; rx_stall_pct = 25;
                end
                3: begin
                    width_val = 7'd127; send_idle_pct = 0;  rx_stall_pct = 0;
                end
                4: begin
                    width_val = 7'd3;   send_idle_pct = 75; rx_stall_pct = 0;
                end
                5: begin
                    width_val = 7'd33;  send_idle_pct = 0;  rx_stall_pct = 0;
                end
                6: begin
                    width_val = 7'd16;  send_idle_pct = 0;  rx_stall_pct = 75;
                end
                default: begin
                    width_val = 7'd5;   send_idle_pct = 25; rx_stall_pct = 25;
                end
            endcase
            load_row_width(width_val);
            @(posedge aclk);
            eff = clamp_width(width_val);
            nrows = TABLE_WORDS / eff;
            known_rows.delete();
            made = 0;

            // At one column per row the highest row index is in range and
            // reads the top table word written in the directed bag.
            if (eff == 1) begin
                push_item(OP_ACCUM, $urandom, $urandom, 65535);
                push_item(OP_ACCUM, $urandom, $urandom, 65535);
                push_item(OP_CLOSE, $urandom, $urandom, $urandom);
                made += 3;
            end

            while (made < PHASE_ITEMS) begin
                // Load a whole row before it may be pooled; narrow widths get
                // more rows since they are cheap to fill.
                if (known_rows.size() == 0 ||
                    (known_rows.size() < 6 && eff <= 8 && $urandom_range(2) == 0)) begin
                    if ($urandom_range(1) == 1) begin
                        pick = $urandom_range(nrows - 1);
                    end else begin
                        pick = $urandom_range(nrows < 64 ? nrows - 1 : 63);
                    end
                    for (c = 0; c < eff; c++) begin
                        push_item(OP_WRITE, pick * eff + c, rand_word(), $urandom);
                    end
                    made += eff;
                    known_rows.push_back(pick[15:0]);
                end
                n = $urandom_range(4);
                for (k = 0; k < n; k++) begin
                    // Every row index from the first one past the table end
                    // up to the highest is out of range.
                    if (eff >= 2 && $urandom_range(99) < 12) begin
                        pick = $urandom_range(65535, nrows);
                    end else begin
                        pick = {16'd0, known_rows[$urandom_range(known_rows.size() - 1)]};
                    end
                    push_item(OP_ACCUM, $urandom, $urandom, pick);
                    made++;
                    if ($urandom_range(9) == 0) begin
                        push_item(OP_WRITE, $urandom, rand_word(), $urandom);
                        made++;
                    end
                    if ($urandom_range(11) == 0) begin
                        push_item(OP_UNUSED, $urandom, $urandom, $urandom);
                    end
                end
                push_item(OP_CLOSE, $urandom, $urandom, $urandom);
                made++;
            end

            // Hold the output channel off while the sender keeps offering, so
            // that a pending row backs up into the input.
            if (phase == 5) begin
                @(posedge aclk);
                -> hold_start;
            end
            wait_for_quiet();
        end

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
